// File: design/c3ck_pkg.sv
// Shared constants for the 3x3 custom kernel filter.
// No dependencies; imported by the stream interface, top level, checker and testbench files.
package c3ck_pkg;

	localparam int MAX_WIDTH_DEF   = 2048;
	localparam int SAMPLE_BITS_DEF = 8;

	localparam int WEIGHT_BITS  = 16;
	localparam int CFG_BITS     = 48;
	localparam int CFG_IDX_BITS = 3;
	localparam int DIV_BITS     = 21;
	localparam int WFIELD_BITS  = 12;
	localparam int HFIELD_BITS  = 13;
	localparam int RESULT_BITS  = 28;
	localparam int WSUM_BITS    = WEIGHT_BITS + 4;

	// result when both divisor and weight sum are zero
	localparam int ZERO_DIV_VALUE = 255;

	// register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_TOP_W    = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_MID_W    = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_BOT_W    = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_DIVISOR  = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH    = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT   = 3'd5;

	localparam logic [CFG_BITS-1:0] MID_W_RESET = 48'h0000_0001_0000;

endpackage

// File: design/c3ck_stream_if.sv
// Valid/ready stream interfaces for the pixel input and the result output.
// Depends on c3ck_pkg for the result width.
interface c3ck_pix_if #(parameter int SAMPLE_BITS = 8);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] pixel_sample;
	modport source (output valid, output pixel_sample, input ready);
	modport sink (input valid, input pixel_sample, output ready);
endinterface

interface c3ck_res_if import c3ck_pkg::*; ;
	logic                   valid;
	logic                   ready;
	logic [RESULT_BITS-1:0] filtered_value;
	logic                   last_of_run;
	logic                   end_of_frame;
	modport source (output valid, output filtered_value, output last_of_run,
		output end_of_frame, input ready);
	modport sink (input valid, input filtered_value, input last_of_run,
		input end_of_frame, output ready);
endinterface

// File: design/conv3x3_custom_kernel.sv
// 3x3 weighted neighborhood filter, top level.
// Depends on c3ck_pkg, c3ck_stream_if (both interfaces) and c3ck_ram.
//
// Usage: pixels carries one sample per transfer in raster order; results
// carries filtered_value with last_of_run and end_of_frame. Registers are
// written through cfg_we / cfg_index / cfg_data; the user must do so only
// while the block is idle, which the block itself does not enforce.
// Results trail the input by one row: a sample inside a row yields the
// result for the previous column, the last column of a row also yields its
// own, and the last row of a frame is sent while the next frame's first row
// arrives. Edge neighbors repeat the nearest edge pixel.
// One sample at a time. Each result is a multiply-accumulate through one
// shared multiplier, a setup step, a restoring division, then a load of
// the output register.
// The two previous rows live in one RAM of MAX_WIDTH entries (two samples per
// entry), read in the accept cycle and written back in the next cycle.
// Reset clears position counters, window and control; the RAM is not cleared.
// A stalled receiver holds the output register; the block then stops before
// loading the next result and takes no new sample until it is sent.
module conv3x3_custom_kernel import c3ck_pkg::*; #(
	parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]     cfg_data,
	c3ck_pix_if.sink                pixels,
	c3ck_res_if.source              results
);
	localparam int CW  = MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1;
	localparam int NW  = 16;
	localparam int PW  = WEIGHT_BITS + SAMPLE_BITS + 1;
	localparam int AW  = WEIGHT_BITS + SAMPLE_BITS + 5;
	localparam int QCW = $clog2(AW + 1);
	localparam int SB  = SAMPLE_BITS;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_READ = 3'd1;
	localparam logic [2:0] ST_MAC  = 3'd2;
	localparam logic [2:0] ST_PREP = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [CFG_BITS-1:0]    top_w_q, mid_w_q, bot_w_q;
	logic [DIV_BITS-1:0]    div_q;
	logic [WFIELD_BITS-1:0] width_q;
	logic [HFIELD_BITS-1:0] height_q;

	logic [2:0]             state_q;
	logic [CW-1:0]          col_q, idx_q;
	logic [HFIELD_BITS-1:0] row_q;
	logic                   tail_q;
	logic [SB-1:0]          pix_q;
	logic [SB-1:0]          win_q [3][3];
	logic                   czero_q, rzero_q, emit0_q, emit1_q, flush_q, sel_q;

	logic [1:0]             tr_q, tc_q;
	logic                   drain_q, prod_vld_s1;
	logic signed [PW-1:0]   prod_s1;
	logic signed [AW-1:0]   acc_q;
	logic signed [WSUM_BITS-1:0] wsum_q;
	logic [DIV_BITS-1:0]    dmag_q;
	logic [DIV_BITS-1:0]    rem_q;
	logic [AW-1:0]          num_q;
	logic                   neg_q;
	logic [QCW-1:0]         dcnt_q;

	logic                   res_valid_q, res_last_q, res_eof_q;
	logic [RESULT_BITS-1:0] res_val_q;

	logic                   accept;
	logic [NW-1:0]          w_eff, col_next;
	logic [HFIELD_BITS-1:0] h_eff;
	logic                   last_col, last_row;
	logic                   re_mem, we_mem;
	logic [2*SB-1:0]        rdata, wdata;
	logic [SB-1:0]          above2, above1;
	logic [SB-1:0]          colv [3];
	logic [CFG_BITS-1:0]    wreg;
	logic signed [WEIGHT_BITS-1:0] wsel;
	logic [SB-1:0]          xsel;
	logic [1:0]             wc;
	logic signed [DIV_BITS-1:0] dsel;
	logic [AW-1:0]          acc_mag;
	logic [DIV_BITS:0]      rem_sh;
	logic                   qbit;
	logic [AW-1:0]          qval;
	logic                   out_free;

	assign accept = pixels.valid && pixels.ready;
	assign pixels.ready = (state_q == ST_IDLE);

	always_comb begin
		if (width_q == '0) begin
			w_eff = NW'(1);
		end else if (NW'(width_q) > NW'(MAX_WIDTH)) begin
			w_eff = NW'(MAX_WIDTH);
		end else begin
			w_eff = NW'(width_q);
		end
		h_eff    = (height_q == '0) ? HFIELD_BITS'(1) : height_q;
		col_next = NW'(col_q) + NW'(1);
		last_col = (col_next >= w_eff);
		last_row = ({1'b0, row_q} + (HFIELD_BITS+1)'(1)) >= {1'b0, h_eff};
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_w_q  <= '0;
			mid_w_q  <= MID_W_RESET;
			bot_w_q  <= '0;
			div_q    <= '0;
			width_q  <= WFIELD_BITS'(2048);
			height_q <= HFIELD_BITS'(2048);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TOP_W:   top_w_q  <= cfg_data;
				REG_MID_W:   mid_w_q  <= cfg_data;
				REG_BOT_W:   bot_w_q  <= cfg_data;
				REG_DIVISOR: div_q    <= cfg_data[DIV_BITS-1:0];
				REG_WIDTH:   width_q  <= cfg_data[WFIELD_BITS-1:0];
				REG_HEIGHT:  height_q <= cfg_data[HFIELD_BITS-1:0];
				default: ;
			endcase
		end
	end

	// line store: high half is the row two above, low half the row above
	assign re_mem = accept;
	assign we_mem = (state_q == ST_READ);
	assign above2 = rdata[2*SB-1:SB];
	assign above1 = rdata[SB-1:0];
	assign wdata  = rzero_q ? {pix_q, pix_q} : {above1, pix_q};

	c3ck_ram #(.WIDTH(2*SB), .DEPTH(MAX_WIDTH)) u_line (
		.clk   (clk),
		.we    (we_mem),
		.waddr (idx_q),
		.wdata (wdata),
		.re    (re_mem),
		.raddr (col_q),
		.rdata (rdata)
	);

	always_comb begin
		colv[0] = above2;
		colv[1] = above1;
		colv[2] = rzero_q ? above1 : pix_q;
	end

	// tap selection for the shared multiplier
	always_comb begin
		case (tr_q)
			2'd0:    wreg = top_w_q;
			2'd1:    wreg = mid_w_q;
			default: wreg = bot_w_q;
		endcase
		case (tc_q)
			2'd0:    wsel = $signed(wreg[15:0]);
			2'd1:    wsel = $signed(wreg[31:16]);
			default: wsel = $signed(wreg[47:32]);
		endcase
		// second result of a row end uses columns 1,2,2
		if (sel_q) begin
			wc = (tc_q == 2'd0) ? 2'd1 : 2'd2;
		end else begin
			wc = tc_q;
		end
		case (wc)
			2'd0:    xsel = win_q[tr_q][0];
			2'd1:    xsel = win_q[tr_q][1];
			default: xsel = win_q[tr_q][2];
		endcase
	end

	always_comb begin
		dsel    = (div_q != '0) ? $signed(div_q)
			: $signed({{(DIV_BITS-WSUM_BITS){wsum_q[WSUM_BITS-1]}}, wsum_q});
		acc_mag = acc_q[AW-1] ? AW'(-acc_q) : AW'(acc_q);
		rem_sh  = {rem_q, num_q[AW-1]};
		qbit    = (rem_sh >= {1'b0, dmag_q});
		qval    = neg_q ? AW'(-num_q) : num_q;
		out_free = !res_valid_q || results.ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			col_q       <= '0;
			row_q       <= '0;
			tail_q      <= 1'b0;
			idx_q       <= '0;
			czero_q     <= 1'b0;
			rzero_q     <= 1'b0;
			emit0_q     <= 1'b0;
			emit1_q     <= 1'b0;
			flush_q     <= 1'b0;
			sel_q       <= 1'b0;
			tr_q        <= '0;
			tc_q        <= '0;
			drain_q     <= 1'b0;
			prod_vld_s1 <= 1'b0;
			dcnt_q      <= '0;
			res_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[i][j] <= '0;
				end
			end
		end else begin
			// drop a sent result unless the next one loads in this cycle
			if (results.valid && results.ready && !(state_q == ST_OUT && out_free)) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						pix_q   <= pixels.pixel_sample;
						idx_q   <= col_q;
						czero_q <= (col_q == '0);
						rzero_q <= (row_q == '0);
						emit0_q <= ((row_q != '0) || tail_q) && (col_q != '0);
						emit1_q <= ((row_q != '0) || tail_q) && last_col;
						flush_q <= (row_q == '0) && tail_q;
						if (last_col) begin
							col_q <= '0;
							if (last_row) begin
								row_q  <= '0;
								tail_q <= 1'b1;
							end else begin
								row_q <= row_q + HFIELD_BITS'(1);
							end
						end else begin
							col_q <= CW'(col_next);
						end
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					for (int k = 0; k < 3; k++) begin
						if (czero_q) begin
							win_q[k][0] <= colv[k];
							win_q[k][1] <= colv[k];
						end else begin
							win_q[k][0] <= win_q[k][1];
							win_q[k][1] <= win_q[k][2];
						end
						win_q[k][2] <= colv[k];
					end
					tr_q        <= '0;
					tc_q        <= '0;
					drain_q     <= 1'b0;
					prod_vld_s1 <= 1'b0;
					acc_q       <= '0;
					wsum_q      <= '0;
					sel_q       <= !emit0_q;
					state_q     <= (emit0_q || emit1_q) ? ST_MAC : ST_IDLE;
				end
				ST_MAC: begin
					if (prod_vld_s1) begin
						acc_q <= acc_q + AW'(prod_s1);
					end
					if (!drain_q) begin
						prod_s1     <= wsel * $signed({1'b0, xsel});
						prod_vld_s1 <= 1'b1;
						wsum_q      <= wsum_q + WSUM_BITS'(wsel);
						if (tc_q == 2'd2) begin
							tc_q <= '0;
							if (tr_q == 2'd2) begin
								drain_q <= 1'b1;
							end else begin
								tr_q <= tr_q + 2'd1;
							end
						end else begin
							tc_q <= tc_q + 2'd1;
						end
					end else begin
						prod_vld_s1 <= 1'b0;
						state_q     <= ST_PREP;
					end
				end
				ST_PREP: begin
					if (dsel == '0) begin
						num_q   <= AW'(ZERO_DIV_VALUE);
						neg_q   <= 1'b0;
						state_q <= ST_OUT;
					end else begin
						dmag_q  <= dsel[DIV_BITS-1] ? DIV_BITS'(-dsel) : DIV_BITS'(dsel);
						num_q   <= acc_mag;
						rem_q   <= '0;
						neg_q   <= acc_q[AW-1] ^ dsel[DIV_BITS-1];
						dcnt_q  <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q  <= qbit ? DIV_BITS'(rem_sh - {1'b0, dmag_q}) : rem_sh[DIV_BITS-1:0];
					num_q  <= {num_q[AW-2:0], qbit};
					dcnt_q <= dcnt_q + QCW'(1);
					if (dcnt_q == QCW'(AW - 1)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					// hold until the output register is free
					if (out_free) begin
						res_valid_q <= 1'b1;
						res_val_q   <= qval[RESULT_BITS-1:0];
						res_last_q  <= sel_q || !emit1_q;
						res_eof_q   <= sel_q && flush_q;
						if (!sel_q && emit1_q) begin
							sel_q       <= 1'b1;
							tr_q        <= '0;
							tc_q        <= '0;
							drain_q     <= 1'b0;
							prod_vld_s1 <= 1'b0;
							acc_q       <= '0;
							wsum_q      <= '0;
							state_q     <= ST_MAC;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign results.valid          = res_valid_q;
	assign results.filtered_value = res_val_q;
	assign results.last_of_run    = res_last_q;
	assign results.end_of_frame   = res_eof_q;
endmodule

// File: design/c3ck_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module c3ck_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// File: design/c3ck_checker.sv
// Port-level assertions for conv3x3_custom_kernel, attached by bind.
// Depends on c3ck_pkg for the result width.
module c3ck_checker import c3ck_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [RESULT_BITS-1:0] out_value,
	input logic                   out_last,
	input logic                   out_eof
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_value) && $stable(out_last)
			&& $stable(out_eof))
		else $error("stalled result changed");

	// a frame-end result closes its run
	a_eof_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_eof |-> out_last)
		else $error("end_of_frame without last_of_run");

	// one sample at a time: no transfer back to back
	a_one_at_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready && !$rose(out_valid))
		else $error("sample accepted while previous one is in work");
endmodule

bind conv3x3_custom_kernel c3ck_checker u_c3ck_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pixels.valid),
	.in_ready  (pixels.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_value (results.filtered_value),
	.out_last  (results.last_of_run),
	.out_eof   (results.end_of_frame)
);

// File: test/conv3x3_custom_kernel_tb.sv
// Self-checking testbench for conv3x3_custom_kernel: directed table, then random frames.
// A local filter model predicts every result. Depends on c3ck_pkg, c3ck_stream_if and the RTL.
module conv3x3_custom_kernel_tb;
	import c3ck_pkg::*;

	typedef struct packed {
		logic [RESULT_BITS-1:0] value;
		logic                   last;
		logic                   eof;
	} filt_res_t;

	typedef struct packed {
		logic                    is_cfg;
		logic [CFG_IDX_BITS-1:0] idx;
		logic [CFG_BITS-1:0]     data;
		logic                    chk;
		logic [RESULT_BITS-1:0]  value;
	} stim_row_t;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_we;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [CFG_BITS-1:0]     cfg_data;

	c3ck_pix_if #(.SAMPLE_BITS(SAMPLE_BITS_DEF)) pix_ch ();
	c3ck_res_if res_ch ();

	conv3x3_custom_kernel dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.pixels(pix_ch), .results(res_ch)
	);

	// model state
	logic [CFG_BITS-1:0] kern_row[3];
	logic [DIV_BITS-1:0] div_r;
	logic [WFIELD_BITS-1:0] width_r;
	logic [HFIELD_BITS-1:0] height_r;
	logic [7:0] rows_back2[MAX_WIDTH_DEF];
	logic [7:0] rows_back1[MAX_WIDTH_DEF];
	logic [7:0] win[3][3];
	int col_pos, row_pos;
	bit tail_pending;

	filt_res_t expected_q[$];
	int n_items, n_results, n_errors, n_frames;
	int send_idle, recv_idle;
	int hold_left;
	bit hold_go;
	bit in_cfg;

	localparam int SETTLE = 60;
	// widest frame the run uses
	localparam int FILL_W = 64;

	stim_row_t dir_tab[] = '{
		'{1'b1, REG_TOP_W,   48'h0,              1'b0, 28'd0},
		'{1'b1, REG_MID_W,   48'h0,              1'b0, 28'd0},
		'{1'b1, REG_BOT_W,   48'h0,              1'b0, 28'd0},
		'{1'b1, REG_DIVISOR, 48'h0,              1'b0, 28'd0},
		'{1'b1, REG_WIDTH,   48'd1,              1'b0, 28'd0},
		'{1'b1, REG_HEIGHT,  48'd1,              1'b0, 28'd0},
		// zero weights and zero divisor: every result is the fixed value
		'{1'b0, 3'd0,        48'd255,            1'b1, 28'd255},
		'{1'b0, 3'd0,        48'd0,              1'b1, 28'd255},
		'{1'b1, REG_MID_W,   48'h0000_0001_0000, 1'b0, 28'd0},
		'{1'b1, REG_DIVISOR, 48'd1,              1'b0, 28'd0},
		'{1'b1, REG_WIDTH,   48'd3,              1'b0, 28'd0},
		'{1'b1, REG_HEIGHT,  48'd2,              1'b0, 28'd0},
		'{1'b0, 3'd0,        48'd0,              1'b0, 28'd0},
		'{1'b0, 3'd0,        48'd255,            1'b0, 28'd0},
		'{1'b0, 3'd0,        48'd17,             1'b0, 28'd0},
		'{1'b0, 3'd0,        48'd200,            1'b0, 28'd0},
		'{1'b0, 3'd0,        48'd1,              1'b0, 28'd0},
		'{1'b0, 3'd0,        48'd128,            1'b0, 28'd0},
		'{1'b1, REG_TOP_W,   48'h7FFF_7FFF_7FFF, 1'b0, 28'd0},
		'{1'b1, REG_MID_W,   48'h7FFF_7FFF_7FFF, 1'b0, 28'd0},
		'{1'b1, REG_BOT_W,   48'h7FFF_7FFF_7FFF, 1'b0, 28'd0},
		'{1'b1, REG_DIVISOR, 48'h0,              1'b0, 28'd0},
		'{1'b0, 3'd0,        48'd255,            1'b0, 28'd0},
		'{1'b0, 3'd0,        48'd255,            1'b0, 28'd0},
		'{1'b0, 3'd0,        48'd255,            1'b0, 28'd0},
		'{1'b1, REG_DIVISOR, 48'h1F_FFFF,        1'b0, 28'd0},
		'{1'b0, 3'd0,        48'd0,              1'b0, 28'd0},
		'{1'b0, 3'd0,        48'd0,              1'b0, 28'd0},
		'{1'b0, 3'd0,        48'd0,              1'b0, 28'd0},
		'{1'b1, REG_TOP_W,   48'h8000_8000_8000, 1'b0, 28'd0},
		'{1'b1, REG_MID_W,   48'h8000_8000_8000, 1'b0, 28'd0},
		'{1'b1, REG_BOT_W,   48'h8000_8000_8000, 1'b0, 28'd0},
		'{1'b1, REG_DIVISOR, 48'h10_0000,        1'b0, 28'd0},
		'{1'b0, 3'd0,        48'd255,            1'b0, 28'd0},
		'{1'b0, 3'd0,        48'd255,            1'b0, 28'd0},
		'{1'b0, 3'd0,        48'd255,            1'b0, 28'd0},
		'{1'b1, REG_DIVISOR, 48'h0F_FFFF,        1'b0, 28'd0},
		'{1'b1, REG_WIDTH,   48'd0,              1'b0, 28'd0},
		'{1'b1, REG_HEIGHT,  48'd0,              1'b0, 28'd0},
		'{1'b0, 3'd0,        48'd255,            1'b0, 28'd0},
		'{1'b0, 3'd0,        48'd0,              1'b0, 28'd0}
	};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("conv3x3_custom_kernel_tb: errors");
		$finish;
	end

	function automatic longint weight_at(int r, int k);
		return longint'($signed(kern_row[r][16*k +: 16]));
	endfunction

	function automatic logic [RESULT_BITS-1:0] weighted_quotient(int lc, int cc, int rc);
		longint acc, wsum, d;
		int cols[3];
		cols = '{lc, cc, rc};
		acc = 0;
		wsum = 0;
		for (int r = 0; r < 3; r++) begin
			for (int k = 0; k < 3; k++) begin
				acc += weight_at(r, k) * longint'(win[r][cols[k]]);
				wsum += weight_at(r, k);
			end
		end
		d = longint'($signed(div_r));
		if (d == 0) d = wsum;
		if (d == 0) return RESULT_BITS'(ZERO_DIV_VALUE);
		return RESULT_BITS'(acc / d);
	endfunction

	// advance the filter by one sample; queue the results it gives
	function automatic int predict_filter(logic [7:0] p);
		int w, h, idx, n;
		logic [7:0] a2, a1;
		logic [7:0] cv[3];
		bit emit, flush, last_col;
		filt_res_t got[2];
		w = int'(width_r);
		h = int'(height_r);
		if (w == 0) w = 1;
		if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
		if (h == 0) h = 1;
		idx = col_pos < MAX_WIDTH_DEF ? col_pos : MAX_WIDTH_DEF - 1;
		a2 = rows_back2[idx];
		a1 = rows_back1[idx];
		last_col = (col_pos + 1 >= w);
		n = 0;
		if (row_pos == 0) begin
			emit = tail_pending;
			flush = tail_pending;
			cv = '{a2, a1, a1};
			rows_back2[idx] = p;
			rows_back1[idx] = p;
		end else begin
			emit = 1'b1;
			flush = 1'b0;
			cv = '{a2, a1, p};
			rows_back2[idx] = a1;
			rows_back1[idx] = p;
		end
		for (int k = 0; k < 3; k++) begin
			if (col_pos == 0) begin
				win[k][0] = cv[k];
				win[k][1] = cv[k];
			end else begin
				win[k][0] = win[k][1];
				win[k][1] = win[k][2];
			end
			win[k][2] = cv[k];
		end
		if (emit) begin
			if (col_pos >= 1) begin
				got[n] = '{weighted_quotient(0, 1, 2), 1'b0, 1'b0};
				n++;
			end
			if (last_col) begin
				got[n] = '{weighted_quotient(1, 2, 2), 1'b0, flush};
				n++;
			end
			for (int i = 0; i < n; i++) begin
				got[i].last = (i == n - 1);
				expected_q.push_back(got[i]);
			end
		end
		if (last_col) begin
			col_pos = 0;
			if (row_pos + 1 >= h) begin
				row_pos = 0;
				tail_pending = 1'b1;
			end else begin
				row_pos++;
			end
		end else begin
			col_pos++;
		end
		return n;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
		n_errors++;
	endtask

	// receiver: random ready, with an optional long hold-off
	always @(posedge clk) begin
		if (hold_go) begin
			hold_go = 1'b0;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		filt_res_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			n_results++;
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected result", res_ch.filtered_value, 0);
			end else begin
				want = expected_q.pop_front();
				if (res_ch.filtered_value !== want.value)
					report_mismatch("filtered_value", $signed(res_ch.filtered_value),
						$signed(want.value));
				if (res_ch.last_of_run !== want.last)
					report_mismatch("last_of_run", res_ch.last_of_run, want.last);
				if (res_ch.end_of_frame !== want.eof)
					report_mismatch("end_of_frame", res_ch.end_of_frame, want.eof);
			end
		end
	end

	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_TOP_W:   kern_row[0] = data;
			REG_MID_W:   kern_row[1] = data;
			REG_BOT_W:   kern_row[2] = data;
			REG_DIVISOR: div_r = data[DIV_BITS-1:0];
			REG_WIDTH:   width_r = data[WFIELD_BITS-1:0];
			REG_HEIGHT:  height_r = data[HFIELD_BITS-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// hold the input until every result is back, then let the block settle
	task automatic drain();
		pix_ch.valid <= 1'b0;
		while (expected_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic send_pixel(logic [7:0] p, bit chk, logic [RESULT_BITS-1:0] val);
		int n;
		while ($urandom_range(99) < send_idle) begin
			pix_ch.valid <= 1'b0;
			@(posedge clk);
		end
		pix_ch.valid <= 1'b1;
		pix_ch.pixel_sample <= p;
		do @(posedge clk); while (!(pix_ch.valid && pix_ch.ready));
		n_items++;
		n = predict_filter(p);
		if (chk && n > 0) expected_q[expected_q.size() - 1].value = val;
	endtask

	function automatic logic [15:0] pick_weight();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			4: return 16'($urandom_range(1, 8));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [DIV_BITS-1:0] pick_divisor();
		case ($urandom_range(9))
			0, 1, 2: return '0;
			3: return 21'h10_0000;
			4: return 21'h0F_FFFF;
			5: return DIV_BITS'(-$urandom_range(1, 40));
			6: return DIV_BITS'($urandom_range(1, 40));
			default: return DIV_BITS'($urandom);
		endcase
	endfunction

	// hold: stall the receiver while this frame streams in
	task automatic random_frame(bit hold);
		int w, h;
		drain();
		if ($urandom_range(9) == 0) begin
			w = $urandom_range(30, FILL_W);
			h = $urandom_range(1, 2);
		end else begin
			w = $urandom_range(1, 12);
			h = $urandom_range(1, 5);
		end
		if (hold) begin
			w = 12;
			h = 4;
		end
		for (int r = 0; r < 3; r++)
			write_reg(CFG_IDX_BITS'(int'(REG_TOP_W) + r),
				{pick_weight(), pick_weight(), pick_weight()});
		write_reg(REG_DIVISOR, CFG_BITS'(pick_divisor()));
		write_reg(REG_WIDTH, CFG_BITS'(w));
		// height zero counts as one row
		write_reg(REG_HEIGHT, CFG_BITS'((h == 1 && $urandom_range(1)) ? 0 : h));
		cfg_we <= 1'b0;
		if (hold) hold_go = 1'b1;
		for (int i = 0; i < w * h; i++)
			send_pixel(8'($urandom), 1'b0, '0);
		n_frames++;
	endtask

	task automatic random_phase(int s_idle, int r_idle, int target, bit squeeze);
		int start;
		bit hold;
		send_idle = s_idle;
		recv_idle = r_idle;
		start = n_items;
		while (n_items - start < target) begin
			hold = squeeze && (n_items - start > target / 2);
			random_frame(hold);
			if (hold) squeeze = 1'b0;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		pix_ch.valid = 1'b0;
		pix_ch.pixel_sample = '0;
		res_ch.ready = 1'b0;
		hold_go = 1'b0;
		hold_left = 0;
		kern_row = '{48'h0, MID_W_RESET, 48'h0};
		div_r = '0;
		width_r = WFIELD_BITS'(2048);
		height_r = HFIELD_BITS'(2048);
		foreach (rows_back2[i]) begin
			rows_back2[i] = '0;
			rows_back1[i] = '0;
		end
		win = '{default: '0};
		col_pos = 0;
		row_pos = 0;
		tail_pending = 1'b0;
		n_items = 0;
		n_results = 0;
		n_errors = 0;
		n_frames = 0;
		in_cfg = 1'b0;
		send_idle = 28;
		recv_idle = 57;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one row as wide as the widest frame fills the line store before anything reads it
		write_reg(REG_WIDTH, CFG_BITS'(FILL_W));
		write_reg(REG_HEIGHT, 48'd0);
		cfg_we <= 1'b0;
		for (int i = 0; i < FILL_W; i++)
			send_pixel(8'($urandom), 1'b0, '0);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].is_cfg) begin
				if (!in_cfg) drain();
				in_cfg = 1'b1;
				write_reg(dir_tab[i].idx, dir_tab[i].data);
			end else begin
				if (in_cfg) cfg_we <= 1'b0;
				in_cfg = 1'b0;
				send_pixel(dir_tab[i].data[7:0], dir_tab[i].chk, dir_tab[i].value);
			end
		end

		random_phase(28, 57, 120, 1'b0);
		random_phase(57, 28, 120, 1'b0);
		random_phase(0, 0, 120, 1'b1);
		drain();

		$display("run covered %0d samples in %0d random frames, %0d results checked",
			n_items, n_frames, n_results);
		$display("settings swept: clamped width, zero height, zero and extreme divisors");
		if (n_errors == 0 && expected_q.size() == 0) begin
			$display("conv3x3_custom_kernel_tb: clean");
		end else begin
			$display("conv3x3_custom_kernel_tb: errors");
		end
		$finish;
	end

endmodule
